[src/local_window_entropy_filter_top_macros.svh]
// -----------------------------------------------------------------------------
// Local window entropy filter: assertion macros
// Shared property forms for the block's internal checks.
// -----------------------------------------------------------------------------
`ifndef LOCAL_WINDOW_ENTROPY_FILTER_TOP_MACROS_SVH
`define LOCAL_WINDOW_ENTROPY_FILTER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LWEF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LWEF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/lwef_pkg.sv]
// -----------------------------------------------------------------------------
// lwef_pkg
// Types, constants and the log table builder shared by the entropy filter.
// -----------------------------------------------------------------------------
package lwef_pkg;

	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 16;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_W     = 16;
	localparam int LEVEL_IN_W   = 8;
	localparam int ENT_W        = 16;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 11'd1024;
	localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET = 16'd1024;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	// ln table in Q4.60; term difference keeps 40 fraction bits
	localparam int LN_W         = 64;
	localparam int LN_FRAC_DROP = 20;
	localparam int D_W          = LN_W - LN_FRAC_DROP;
	// per-level term in Q0.20, final result drops 6 bits with rounding
	localparam int Q_W          = 20;
	localparam int ROUND_SHIFT  = 6;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FILL_RD,
		ST_FILL_HR,
		ST_FILL_UP,
		ST_SUM_RD,
		ST_SUM_HR,
		ST_SUM_K,
		ST_DIFF,
		ST_MUL,
		ST_ADD,
		ST_DIV,
		ST_ACC,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic accept;
		logic fill_hrd;
		logic fill_upd;
		logic sum_rd;
		logic sum_hrd;
		logic sum_k;
		logic diff;
		logic mul_step;
		logic add;
		logic div_step;
		logic acc;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic emit;
		logic fill_last;
		logic skip;
		logic sum_more;
		logic mul_last;
		logic div_last;
		logic out_free;
	} sts_t;

	// Shift-subtract division, evaluated at elaboration only.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// ln(n) in Q4.60 via ln(m) = ln(m-1) + 2*atanh(1/(2m-1)).
	function automatic logic [63:0] ln_q60(input int n);
		logic [63:0] acc;
		logic [63:0] d;
		logic [63:0] d2;
		logic [63:0] p;
		logic [63:0] s;
		acc = '0;
		for (int m = 2; m <= n; m++) begin
			d  = 64'(2 * m - 1);
			d2 = d * d;
			p  = udiv64(64'h1000_0000_0000_0000, d);
			s  = '0;
			for (int j = 0; j < 64; j++) begin
				if (p != '0) begin
					s = s + udiv64(p, 64'(2 * j + 1));
					p = udiv64(p, d2);
				end
			end
			acc = acc + {s[62:0], 1'b0};
		end
		return acc;
	endfunction

endpackage

[src/lwef_if.sv]
// -----------------------------------------------------------------------------
// lwef_if
// Valid/ready channels for pixel requests and entropy results.
// -----------------------------------------------------------------------------
interface lwef_pix_if;
	import lwef_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  command;
	logic [LEVEL_IN_W-1:0] level;
	modport source (output valid, command, level, input ready);
	modport sink (input valid, command, level, output ready);
endinterface

interface lwef_res_if;
	import lwef_pkg::*;
	logic             valid;
	logic             ready;
	logic [ENT_W-1:0] local_entropy;
	logic             last_of_image;
	modport source (output valid, local_entropy, last_of_image, input ready);
	modport sink (input valid, local_entropy, last_of_image, output ready);
endinterface

[src/local_window_entropy_filter_top.sv]
// -----------------------------------------------------------------------------
// local_window_entropy_filter_top: windowed level-histogram entropy filter
// Flow: a request with no result is taken in IDLE and the block stays ready; one
//   with a result walks the N window pixels into the histogram RAM, reads back its L
//   distinct levels and, for each of the T levels whose count is below N, runs the
//   serial multiply (5 steps) and restoring divide (20 steps); an output stall holds the result load.
// Reset: clears counters and registers, then sweeps all LEVEL_COUNT entries
//   (256 by default) of the histogram RAM before the first request is taken.
// -----------------------------------------------------------------------------
`include "local_window_entropy_filter_top_macros.svh"

module local_window_entropy_filter_top #(
	parameter int MAX_WIDTH   = 1024,
	parameter int WINDOW_SIZE = 5,
	parameter int LEVEL_COUNT = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	lwef_pix_if.sink                        pix,
	lwef_res_if.source                      res,
	input  logic                            wr_en,
	input  logic [lwef_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [lwef_pkg::CFG_DATA_W-1:0] wr_data
);
	import lwef_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Controller: owns the request handshake and sequences every walk.
	lwef_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix.valid),
		.pix_ready (pix.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: line store, histogram and term arithmetic; the result register
	// lives here so the next request can enter while a result waits.
	lwef_dp #(
		.MAX_WIDTH   (MAX_WIDTH),
		.WINDOW_SIZE (WINDOW_SIZE),
		.LEVEL_COUNT (LEVEL_COUNT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.command       (pix.command),
		.level         (pix.level),
		.res_ready     (res.ready),
		.res_valid     (res.valid),
		.local_entropy (res.local_entropy),
		.last_of_image (res.last_of_image)
	);

	// Never drop a pending result.
	`LWEF_ASSERT_SAME(a_load_free, cmd.load_out, sts.out_free, "result overwritten")
	// One histogram writer at a time.
	`LWEF_ASSERT_SAME(a_hist_one, 1'b1, ($onehot0({cmd.clr_step, cmd.fill_upd, cmd.sum_k})), "hist clash")
	// A loaded result shows on the port next cycle.
	`LWEF_ASSERT_NEXT(a_load_shows, cmd.load_out, res.valid, "loaded result not presented")
endmodule

[src/lwef_ram.sv]
// -----------------------------------------------------------------------------
// lwef_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module lwef_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

[src/lwef_ctrl.sv]
// -----------------------------------------------------------------------------
// lwef_ctrl
// Sequencer: histogram clear, window fill, per-level term loop, result load.
// -----------------------------------------------------------------------------
module lwef_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pix_valid,
	output logic          pix_ready,
	input  lwef_pkg::sts_t sts,
	output lwef_pkg::cmd_t cmd
);
	import lwef_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (pix_valid && sts.emit) state_nx = ST_FILL_RD;
			end
			ST_FILL_RD: state_nx = ST_FILL_HR;
			ST_FILL_HR: state_nx = ST_FILL_UP;
			ST_FILL_UP: begin
				state_nx = sts.fill_last ? ST_SUM_RD : ST_FILL_RD;
			end
			ST_SUM_RD: state_nx = ST_SUM_HR;
			ST_SUM_HR: state_nx = ST_SUM_K;
			ST_SUM_K: begin
				if (!sts.skip) state_nx = ST_DIFF;
				else state_nx = sts.sum_more ? ST_SUM_RD : ST_FINISH;
			end
			ST_DIFF: state_nx = ST_MUL;
			ST_MUL: begin
				if (sts.mul_last) state_nx = ST_ADD;
			end
			ST_ADD: state_nx = ST_DIV;
			ST_DIV: begin
				if (sts.div_last) state_nx = ST_ACC;
			end
			ST_ACC: begin
				state_nx = sts.sum_more ? ST_SUM_RD : ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd       = '0;
		pix_ready = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_IDLE: begin
				pix_ready  = 1'b1;
				cmd.accept = pix_valid;
			end
			ST_FILL_HR: cmd.fill_hrd = 1'b1;
			ST_FILL_UP: cmd.fill_upd = 1'b1;
			ST_SUM_RD:  cmd.sum_rd   = 1'b1;
			ST_SUM_HR:  cmd.sum_hrd  = 1'b1;
			ST_SUM_K:   cmd.sum_k    = 1'b1;
			ST_DIFF:    cmd.diff     = 1'b1;
			ST_MUL:     cmd.mul_step = 1'b1;
			ST_ADD:     cmd.add      = 1'b1;
			ST_DIV:     cmd.div_step = 1'b1;
			ST_ACC:     cmd.acc      = 1'b1;
			ST_FINISH:  cmd.load_out = sts.out_free;
			default: cmd = '0;
		endcase
	end
endmodule

[src/lwef_dp.sv]
// -----------------------------------------------------------------------------
// lwef_dp
// Datapath: position counters, line store, histogram, term arithmetic, output.
// -----------------------------------------------------------------------------
module lwef_dp #(
	parameter int MAX_WIDTH   = 1024,
	parameter int WINDOW_SIZE = 5,
	parameter int LEVEL_COUNT = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lwef_pkg::cmd_t                    cmd,
	output lwef_pkg::sts_t                    sts,
	input  logic                              wr_en,
	input  logic [lwef_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [lwef_pkg::CFG_DATA_W-1:0]   wr_data,
	input  logic                              command,
	input  logic [lwef_pkg::LEVEL_IN_W-1:0]   level,
	input  logic                              res_ready,
	output logic                              res_valid,
	output logic [lwef_pkg::ENT_W-1:0]        local_entropy,
	output logic                              last_of_image
);
	import lwef_pkg::*;

	localparam int HALF        = WINDOW_SIZE / 2;
	localparam int SPAN        = 2 * HALF + 1;
	localparam int LINE_ROWS   = 2 * HALF + 2;
	localparam int STORE_DEPTH = LINE_ROWS * MAX_WIDTH;
	localparam int MAX_COUNT   = SPAN * SPAN;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int WID_W       = $clog2(MAX_WIDTH + 1);
	localparam int SLOT_W      = $clog2(LINE_ROWS);
	localparam int SA_W        = $clog2(STORE_DEPTH);
	localparam int LV_W        = $clog2(LEVEL_COUNT);
	localparam int K_W         = $clog2(MAX_COUNT + 1);
	localparam int SEEN_AW     = $clog2(MAX_COUNT);
	localparam int SPAN_W      = $clog2(SPAN);
	localparam int CNT_W       = HEIGHT_W + WID_W;
	localparam int NUM_W       = D_W + K_W + 1;
	localparam int SUM_W       = Q_W + K_W;
	localparam int MB_W        = $clog2(K_W);
	localparam int DB_W        = $clog2(Q_W);

	// configuration
	logic [WIDTH_REG_W-1:0] width_q;
	logic [HEIGHT_W-1:0]    height_q;
	logic [WID_W-1:0]       eff_w;
	logic [HEIGHT_W-1:0]    eff_h;
	logic [CNT_W-1:0]       thresh;

	// stream position
	logic [HEIGHT_W-1:0] in_row_q, out_row_q;
	logic [COL_W-1:0]    in_col_q, out_col_q;
	logic [SLOT_W-1:0]   in_slot_q, out_slot_q;
	logic [CNT_W-1:0]    cnt_q, cnt_nx;

	logic              in_done, out_done, is_pix, pix_take, emit, out_last;
	logic              in_wrap, out_wrap;
	logic [LV_W-1:0]   lv_sat;

	// window walk
	logic [COL_W-1:0]  wx_q, wx0_q, wx1_q;
	logic [SPAN_W-1:0] wrows_q;
	logic [SLOT_W-1:0] wslot_q;
	logic [SPAN_W-1:0] back_r, fwd_r;
	logic [COL_W-1:0]  c0, c1;
	logic [SLOT_W-1:0] slot0;

	// histogram pass
	logic [LV_W-1:0]    clr_idx_q;
	logic [LV_W-1:0]    lv_q;
	logic [K_W-1:0]     total_q, distinct_q, idx_q, k_q;
	logic [LV_W-1:0]    store_rd, seen_rd;
	logic [K_W-1:0]     hist_rd;
	logic               hist_we;
	logic [LV_W-1:0]    hist_wa, hist_ra;
	logic [K_W-1:0]     hist_wd;

	// term arithmetic
	logic [LN_W-1:0]    ln_tab [MAX_COUNT + 1];
	logic [LN_W-1:0]    ln_diff;
	logic [D_W-1:0]     d_q;
	logic [NUM_W-1:0]   acc_q, rem_q, den_q;
	logic [MB_W-1:0]    mb_q;
	logic [DB_W-1:0]    db_q;
	logic [Q_W-1:0]     q_q;
	logic [SUM_W-1:0]   sum_q;
	logic [SUM_W:0]     rnd_sum;
	logic               last_q;
	logic               res_valid_q;
	logic [ENT_W-1:0]   ent_q;

	// constant log table
	for (genvar g = 0; g <= MAX_COUNT; g++) begin : g_ln
		localparam logic [LN_W-1:0] LN_VAL = ln_q60(g);
		assign ln_tab[g] = LN_VAL;
	end

	always_comb begin
		if (width_q == '0) eff_w = WID_W'(1);
		else if (32'(width_q) > MAX_WIDTH) eff_w = WID_W'(MAX_WIDTH);
		else eff_w = WID_W'(width_q);
	end
	assign eff_h  = (height_q == '0) ? HEIGHT_W'(1) : height_q;
	assign thresh = CNT_W'(HALF) * CNT_W'(eff_w) + CNT_W'(HALF);

	assign lv_sat = (32'(level) >= LEVEL_COUNT) ? LV_W'(LEVEL_COUNT - 1) : LV_W'(level);

	assign in_done  = in_row_q >= eff_h;
	assign out_done = out_row_q >= eff_h;
	assign is_pix   = command == CMD_PIXEL;
	assign pix_take = is_pix && !in_done;
	assign cnt_nx   = cnt_q + CNT_W'(1);
	assign emit     = is_pix ? (pix_take && (cnt_nx > thresh) && !out_done)
	                         : (in_done && !out_done);
	assign in_wrap  = (WID_W'(in_col_q) + WID_W'(1)) >= eff_w;
	assign out_wrap = (WID_W'(out_col_q) + WID_W'(1)) >= eff_w;
	assign out_last = (out_row_q == eff_h - HEIGHT_W'(1)) && out_wrap;

	// clipped window around the next output pixel
	always_comb begin
		back_r = (32'(out_row_q) > HALF) ? SPAN_W'(HALF) : SPAN_W'(out_row_q);
		if (32'(out_row_q) + HALF < 32'(eff_h)) fwd_r = SPAN_W'(HALF);
		else fwd_r = SPAN_W'(32'(eff_h) - 1 - 32'(out_row_q));
		c0 = (32'(out_col_q) > HALF) ? COL_W'(32'(out_col_q) - HALF) : '0;
		if (32'(out_col_q) + HALF < 32'(eff_w)) c1 = COL_W'(32'(out_col_q) + HALF);
		else c1 = COL_W'(32'(eff_w) - 1);
		if (out_slot_q >= SLOT_W'(back_r)) slot0 = out_slot_q - SLOT_W'(back_r);
		else slot0 = SLOT_W'(32'(out_slot_q) + LINE_ROWS - 32'(back_r));
	end

	// configuration and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= WIDTH_RESET;
			height_q   <= HEIGHT_RESET;
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_slot_q  <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_slot_q <= '0;
			cnt_q      <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_IMAGE_WIDTH:  width_q  <= wr_data[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= wr_data[HEIGHT_W-1:0];
				default: ;
			endcase
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_slot_q  <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_slot_q <= '0;
			cnt_q      <= '0;
		end else if (cmd.accept) begin
			if (pix_take) begin
				cnt_q <= cnt_nx;
				if (in_wrap) begin
					in_col_q  <= '0;
					in_row_q  <= in_row_q + HEIGHT_W'(1);
					in_slot_q <= (in_slot_q == SLOT_W'(LINE_ROWS - 1)) ? '0
					           : in_slot_q + SLOT_W'(1);
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
			end
			if (emit) begin
				if (out_last) begin
					in_row_q   <= '0;
					in_col_q   <= '0;
					in_slot_q  <= '0;
					out_row_q  <= '0;
					out_col_q  <= '0;
					out_slot_q <= '0;
					cnt_q      <= '0;
				end else if (out_wrap) begin
					out_col_q  <= '0;
					out_row_q  <= out_row_q + HEIGHT_W'(1);
					out_slot_q <= (out_slot_q == SLOT_W'(LINE_ROWS - 1)) ? '0
					            : out_slot_q + SLOT_W'(1);
				end else begin
					out_col_q <= out_col_q + COL_W'(1);
				end
			end
		end
	end

	// line store
	lwef_ram #(.WIDTH(LV_W), .DEPTH(STORE_DEPTH)) u_line_store (
		.clk     (clk),
		.we      (cmd.accept && pix_take),
		.wr_addr (SA_W'(in_slot_q) * SA_W'(MAX_WIDTH) + SA_W'(in_col_q)),
		.wr_data (lv_sat),
		.rd_addr (SA_W'(wslot_q) * SA_W'(MAX_WIDTH) + SA_W'(wx_q)),
		.rd_data (store_rd)
	);

	// histogram, cleared by sweep after reset and by the sum pass afterwards
	assign hist_we = cmd.clr_step || cmd.fill_upd || cmd.sum_k;
	assign hist_wa = cmd.clr_step ? clr_idx_q : lv_q;
	assign hist_wd = cmd.fill_upd ? hist_rd + K_W'(1) : '0;
	assign hist_ra = cmd.fill_hrd ? store_rd : seen_rd;

	lwef_ram #(.WIDTH(K_W), .DEPTH(LEVEL_COUNT)) u_hist (
		.clk     (clk),
		.we      (hist_we),
		.wr_addr (hist_wa),
		.wr_data (hist_wd),
		.rd_addr (hist_ra),
		.rd_data (hist_rd)
	);

	// list of levels seen in the window
	lwef_ram #(.WIDTH(LV_W), .DEPTH(MAX_COUNT)) u_seen (
		.clk     (clk),
		.we      (cmd.fill_upd && (hist_rd == '0)),
		.wr_addr (distinct_q[SEEN_AW-1:0]),
		.wr_data (lv_q),
		.rd_addr (idx_q[SEEN_AW-1:0]),
		.rd_data (seen_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clr_step) begin
			clr_idx_q <= clr_idx_q + LV_W'(1);
		end
	end

	assign ln_diff = ln_tab[total_q] - ln_tab[k_q];
	assign rnd_sum = {1'b0, sum_q} + (SUM_W + 1)'(1 << (ROUND_SHIFT - 1));

	// walk, histogram and term registers
	always_ff @(posedge clk) begin
		if (cmd.accept && emit) begin
			wx_q       <= c0;
			wx0_q      <= c0;
			wx1_q      <= c1;
			wrows_q    <= back_r + fwd_r;
			wslot_q    <= slot0;
			total_q    <= '0;
			distinct_q <= '0;
			idx_q      <= '0;
			sum_q      <= '0;
			last_q     <= out_last;
		end
		if (cmd.fill_hrd) lv_q <= store_rd;
		if (cmd.sum_hrd)  lv_q <= seen_rd;
		if (cmd.fill_upd) begin
			total_q <= total_q + K_W'(1);
			if (hist_rd == '0) distinct_q <= distinct_q + K_W'(1);
			if (wx_q == wx1_q) begin
				wx_q    <= wx0_q;
				wrows_q <= wrows_q - SPAN_W'(1);
				wslot_q <= (wslot_q == SLOT_W'(LINE_ROWS - 1)) ? '0 : wslot_q + SLOT_W'(1);
			end else begin
				wx_q <= wx_q + COL_W'(1);
			end
		end
		if (cmd.sum_rd) idx_q <= idx_q + K_W'(1);
		if (cmd.sum_k)  k_q   <= hist_rd;
		if (cmd.diff) begin
			d_q   <= ln_diff[LN_W-1:LN_FRAC_DROP];
			acc_q <= '0;
			mb_q  <= MB_W'(K_W - 1);
		end
		if (cmd.mul_step) begin
			acc_q <= (acc_q << 1) + (k_q[mb_q] ? NUM_W'(d_q) : '0);
			mb_q  <= mb_q - MB_W'(1);
		end
		if (cmd.add) begin
			rem_q <= acc_q + (NUM_W'(total_q) << (LN_FRAC_DROP - 1));
			den_q <= NUM_W'(total_q) << (LN_FRAC_DROP + Q_W - 1);
			db_q  <= DB_W'(Q_W - 1);
			q_q   <= '0;
		end
		if (cmd.div_step) begin
			if (rem_q >= den_q) begin
				rem_q <= rem_q - den_q;
				q_q   <= {q_q[Q_W-2:0], 1'b1};
			end else begin
				q_q <= {q_q[Q_W-2:0], 1'b0};
			end
			den_q <= den_q >> 1;
			db_q  <= db_q - DB_W'(1);
		end
		if (cmd.acc) sum_q <= sum_q + SUM_W'(q_q);
		if (cmd.load_out) begin
			ent_q <= (rnd_sum[SUM_W:ENT_W+ROUND_SHIFT] != '0) ? '1
			       : rnd_sum[ENT_W+ROUND_SHIFT-1:ROUND_SHIFT];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	logic last_out_q;
	always_ff @(posedge clk) begin
		if (cmd.load_out) last_out_q <= last_q;
	end

	assign res_valid     = res_valid_q;
	assign local_entropy = ent_q;
	assign last_of_image = last_out_q;

	assign sts.clr_last  = clr_idx_q == LV_W'(LEVEL_COUNT - 1);
	assign sts.emit      = emit;
	assign sts.fill_last = (wx_q == wx1_q) && (wrows_q == '0);
	assign sts.skip      = (hist_rd == '0) || (hist_rd >= total_q);
	assign sts.sum_more  = idx_q < distinct_q;
	assign sts.mul_last  = mb_q == '0;
	assign sts.div_last  = db_q == '0;
	assign sts.out_free  = !res_valid_q || res_ready;
endmodule

[dv/local_window_entropy_filter_top_tb.sv]
// -----------------------------------------------------------------------------
// local_window_entropy_filter_top_tb: self-checking bench for the entropy filter
// Streams small raster images with random levels, drain ticks and stray
// requests through the pixel channel and checks every entropy result against
// an in-bench window histogram predictor, under random idling on both sides.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module local_window_entropy_filter_top_tb;
	import lwef_pkg::*;

	localparam int HALF       = 2;
	localparam int LINE_ROWS  = 2 * HALF + 2;
	localparam int MAX_W      = 1024;
	localparam int MAX_N      = (2 * HALF + 1) * (2 * HALF + 1);
	localparam int IDLE_LIMIT = 20000;
	localparam int LONG_HOLD  = 3000;
	localparam int SETTLE     = 20;
	localparam int DRAIN_WAIT = 1000;

	typedef struct packed {
		logic [ENT_W-1:0] local_entropy;
		logic             last_of_image;
	} entropy_result_t;

	// Window histogram predictor and the queue of entropy results it expects.
	class entropy_scoreboard;
		longint unsigned ln_q60 [MAX_N+1];
		logic [7:0]      pixel_rows [LINE_ROWS*MAX_W];
		int unsigned     width_reg, height_reg;
		int unsigned     in_row, in_col, out_row, out_col;
		entropy_result_t expected_q [$];
		int              mismatches;

		function new();
			longint unsigned d, d2, p, s, j;
			ln_q60[0] = 0;
			ln_q60[1] = 0;
			for (int n = 2; n <= MAX_N; n++) begin
				d  = 2 * n - 1;
				d2 = d * d;
				p  = (64'd1 << 60) / d;
				s  = 0;
				j  = 0;
				while (p != 0) begin
					s += p / (2 * j + 1);
					p /= d2;
					j++;
				end
				ln_q60[n] = ln_q60[n-1] + 2 * s;
			end
			foreach (pixel_rows[i]) pixel_rows[i] = '0;
			width_reg  = 1024;
			height_reg = 1024;
			mismatches = 0;
			clear_position();
		endfunction

		function void clear_position();
			in_row = 0; in_col = 0; out_row = 0; out_col = 0;
		endfunction

		function int unsigned eff_w();
			if (width_reg == 0) return 1;
			return (width_reg > MAX_W) ? MAX_W : width_reg;
		endfunction

		function int unsigned eff_h();
			return (height_reg == 0) ? 1 : height_reg;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == REG_IMAGE_WIDTH) width_reg = val[WIDTH_REG_W-1:0];
			else height_reg = val;
			clear_position();
		endfunction

		function int unsigned window_entropy(int unsigned r, int unsigned c,
				int unsigned w, int unsigned h);
			int unsigned     cnt [256];
			int unsigned     seen [$];
			int unsigned     r0, r1, c0, c1, total, lv;
			longint unsigned sum, k, d40, num;
			r0 = (r > HALF) ? r - HALF : 0;
			r1 = (r + HALF < h) ? r + HALF : h - 1;
			c0 = (c > HALF) ? c - HALF : 0;
			c1 = (c + HALF < w) ? c + HALF : w - 1;
			total = 0;
			sum   = 0;
			for (int unsigned y = r0; y <= r1; y++)
				for (int unsigned x = c0; x <= c1; x++) begin
					lv = pixel_rows[(y % LINE_ROWS) * MAX_W + x];
					if (cnt[lv] == 0) seen = {seen, lv};
					cnt[lv]++;
					total++;
				end
			foreach (seen[i]) begin
				k = cnt[seen[i]];
				if (k < total) begin
					d40 = (ln_q60[total] - ln_q60[k]) >> 20;
					num = k * d40 + longint'(total) * (64'd1 << 19);
					sum += num / (longint'(total) << 20);
				end
			end
			sum = (sum + 32) >> ROUND_SHIFT;
			return (sum > 65535) ? 65535 : int'(sum);
		endfunction

		function void push_result(int unsigned w, int unsigned h);
			entropy_result_t e;
			e.local_entropy = ENT_W'(window_entropy(out_row, out_col, w, h));
			e.last_of_image = (out_row == h - 1) && (out_col == w - 1);
			expected_q = {expected_q, e};
			if (e.last_of_image) clear_position();
			else begin
				out_col++;
				if (out_col >= w) begin out_col = 0; out_row++; end
			end
		endfunction

		// Note an accepted request and predict the result it causes, if any.
		function void note_request(logic cmd, logic [7:0] lvl);
			int unsigned     w, h;
			longint unsigned count;
			w = eff_w();
			h = eff_h();
			if (cmd == CMD_PIXEL) begin
				if (in_row >= h) return;
				pixel_rows[(in_row % LINE_ROWS) * MAX_W + in_col] = lvl;
				in_col++;
				if (in_col >= w) begin in_col = 0; in_row++; end
				count = longint'(in_row) * w + in_col;
				if (count <= HALF * w + HALF || out_row >= h) return;
				push_result(w, h);
			end else if (in_row >= h && out_row < h) begin
				push_result(w, h);
			end
		endfunction

		function bit drain_due();
			return in_row >= eff_h() && out_row < eff_h();
		endfunction

		function void check_result(entropy_result_t got);
			entropy_result_t exp_r;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: entropy=%0d last=%0b",
						got.local_entropy, got.last_of_image);
				return;
			end
			exp_r = expected_q.pop_front();
			if (got.local_entropy !== exp_r.local_entropy ||
					got.last_of_image !== exp_r.last_of_image) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: entropy exp=%0d got=%0d, last exp=%0b got=%0b",
						exp_r.local_entropy, got.local_entropy,
						exp_r.last_of_image, got.last_of_image);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	lwef_pix_if pix_ch ();
	lwef_res_if res_ch ();

	local_window_entropy_filter_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix      (pix_ch),
		.res      (res_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	entropy_scoreboard sb = new();

	int sent_requests = 0;  // accepted requests, bounds the random part
	int burst_left    = 0;  // requests left in the current sender burst
	bit long_hold_req = 0;  // ask the receiver for one long stall
	int hold_left     = 0;
	int idle_cycles   = 0;
	int rx_cycle      = 0;
	int rx_mode       = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Receiver: check results, pick a stall pattern, count idle cycles.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready)
				sb.check_result(entropy_result_t'({res_ch.local_entropy,
					res_ch.last_of_image}));
			// watchdog: a cycle with neither request nor result accepted
			if ((res_ch.valid && res_ch.ready) || (pix_ch.valid && pix_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[local_window_entropy_filter_top] ERROR");
				$finish;
			end
		end
		rx_cycle++;
		if (rx_cycle % 300 == 0) rx_mode = $urandom_range(0, 3);
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else if (long_hold_req) begin
			// hold off long enough that the block fills and stalls its input
			long_hold_req = 0;
			hold_left     = LONG_HOLD;
			res_ch.ready <= 1'b0;
		end else begin
			case (rx_mode)
				0: res_ch.ready <= 1'b1;
				1: res_ch.ready <= 1'($urandom_range(0, 1));
				2: res_ch.ready <= ($urandom_range(0, 3) == 0);
				default: res_ch.ready <= (rx_cycle % 7 != 0);
			endcase
		end
	end

	// Offer one request and hold it until the block takes it.
	task automatic send_request(logic cmd, logic [7:0] lvl);
		int gap;
		if (burst_left == 0) begin
			// end of burst: drop valid for a random gap, sometimes a long run next
			pix_ch.valid <= 1'b0;
			gap = $urandom_range(1, 12);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
			                                          : $urandom_range(1, 16);
		end
		pix_ch.valid   <= 1'b1;
		pix_ch.command <= cmd;
		pix_ch.level   <= lvl;
		do @(posedge clk); while (!pix_ch.ready);
		sb.note_request(cmd, lvl);
		sent_requests++;
		burst_left--;
	endtask

	// Pause the sender until every expected result is back.
	task automatic wait_idle();
		pix_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Drive one register write; the caller drops the enable afterwards.
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		sb.set_register(idx, val);
	endtask

	function automatic logic [7:0] pick_level(int mode);
		case (mode)
			0: return 8'($urandom_range(0, 255));
			1: return 8'($urandom_range(0, 3) * 85);  // few levels, big counts
			default: return $urandom_range(0, 1) ? 8'hff : 8'h00;
		endcase
	endfunction

	// Configure one image, stream up to max_pix pixels with some noise,
	// then drain the tail if the image was completed.
	task automatic run_image(int w, int h, int max_pix, int lvl_mode);
		int total_pix;
		wait_idle();
		write_register(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
		write_register(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
		wr_en <= 1'b0;
		total_pix = sb.eff_w() * sb.eff_h();
		if (total_pix > max_pix) total_pix = max_pix;
		for (int i = 0; i < total_pix; i++) begin
			// a drain before the image is complete returns nothing
			if ($urandom_range(0, 19) == 0) send_request(CMD_DRAIN, 8'($urandom_range(0, 255)));
			send_request(CMD_PIXEL, pick_level(lvl_mode));
		end
		while (sb.drain_due()) begin
			// pixels while results are pending are ignored
			if ($urandom_range(0, 9) == 0) send_request(CMD_PIXEL, 8'($urandom_range(0, 255)));
			send_request(CMD_DRAIN, 8'($urandom_range(0, 255)));
		end
		// drain with nothing pending
		if ($urandom_range(0, 3) == 0) send_request(CMD_DRAIN, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		int w, h;
		arst_n         = 1'b0;
		wr_en          <= 1'b0;
		wr_index       <= REG_IMAGE_WIDTH;
		wr_data        <= '0;
		pix_ch.valid   <= 1'b0;
		pix_ch.command <= CMD_PIXEL;
		pix_ch.level   <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// let the histogram clearing sweep finish
		repeat (300) @(posedge clk);

		// directed: single pixel, zero sizes, level extremes, tiny images
		run_image(1, 1, 1, 2);
		run_image(0, 0, 1, 0);
		run_image(3, 2, 6, 2);
		run_image(5, 1, 5, 1);
		// widest row with the height at its register extreme, aborted by the next write
		run_image(1024, 65535, 8, 0);
		// width beyond the limit, partial row aborted by the next write
		run_image(2047, 1, 16, 1);

		// full image with many results; stall the receiver meanwhile
		long_hold_req = 1;
		run_image(40, 6, 300, 1);

		while (sent_requests < 1700) begin
			w = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			h = $urandom_range(1, 6);
			if ($urandom_range(0, 15) == 0) w = 0;
			if ($urandom_range(0, 15) == 0) h = 0;
			if ($urandom_range(0, 30) == 0) h = 65535;
			run_image(w, h, 300, $urandom_range(0, 2));
			if ($urandom_range(0, 25) == 0) long_hold_req = 1;
		end

		wait_idle();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.expected_q.size() != 0) sb.mismatches++;
		if (sb.mismatches == 0)
			$display("[local_window_entropy_filter_top] OK");
		else
			$display("[local_window_entropy_filter_top] ERROR");
		$finish;
	end

endmodule
